/* rtl/gaussian_row_smoother_core_assert.svh */
// assertion macros for the gaussian row smoother
// used by the top level; needs clk and rst_n in scope
`ifndef GAUSSIAN_ROW_SMOOTHER_CORE_ASSERT_SVH
`define GAUSSIAN_ROW_SMOOTHER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GRS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRS_ASSERT(lbl, prop, msg)
`define GRS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/grs_pkg.sv */
// shared types and constants of the gaussian row smoother
// no dependencies
package grs_pkg;
  localparam int SAMPLE_W       = 32;
  localparam int COEF_W         = 17;
  localparam int NUM_COEF       = 5;
  localparam int POS_W          = 3;
  localparam int DEF_HALF_WIDTH = 4;
  localparam int DEF_MAX_ROW    = 4096;

  typedef enum logic [2:0] {
    CFG_MEAN_MODE = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_COEF_0    = 3'd2,
    CFG_COEF_1    = 3'd3,
    CFG_COEF_2    = 3'd4,
    CFG_COEF_3    = 3'd5,
    CFG_COEF_4    = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MAC, BK_ROUND, BK_WRITE, BK_NEXT, BK_DSET, BK_DIV, BK_MWRITE
  } back_state_t;

  typedef struct packed {
    logic             last;
    logic             first;
    logic             mean_mode;
    logic [POS_W-1:0] pos;
  } job_ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic                last_of_row;
    logic                no_kept;
  } result_t;
endpackage

/* rtl/grs_fifo.sv */
// two-entry queue of register slots
// depends on nothing but its width parameter
module grs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= wdata;
  end
endmodule

/* rtl/grs_front.sv */
// front part: row position and thresholded mean accumulation, builds jobs
// depends on grs_pkg
module grs_front import grs_pkg::*; #(
  parameter int HALF_WIDTH = DEF_HALF_WIDTH,
  parameter int MAX_ROW    = DEF_MAX_ROW,
  localparam int CNT_W     = $clog2(MAX_ROW + 1),
  localparam int SUM_W     = SAMPLE_W + CNT_W,
  localparam int JOB_W     = $bits(job_ctl_t) + SAMPLE_W + SUM_W + CNT_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_in_row,
  input  logic                       in_push,
  input  logic                       job_full,
  input  logic                       mean_mode,
  input  logic signed [SAMPLE_W-1:0] keep_threshold,
  output logic                       job_push,
  output logic [JOB_W-1:0]           job_data
);
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_new;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt, cnt_new;
  logic                    keep;
  job_ctl_t                ctl;

  assign job_push = in_push && !job_full;

  always_comb begin
    keep    = (pos_r < CNT_W'(MAX_ROW)) && (in_sample <= keep_threshold);
    sum_new = keep ? sum_r + SUM_W'(in_sample) : sum_r;
    cnt_new = keep ? cnt_r + CNT_W'(1) : cnt_r;
    ctl.last      = in_last_in_row;
    ctl.first     = (pos_r == '0);
    ctl.mean_mode = mean_mode;
    ctl.pos       = (pos_r >= CNT_W'(HALF_WIDTH)) ? POS_W'(HALF_WIDTH) : pos_r[POS_W-1:0];
    job_data = {ctl, in_sample, sum_new, cnt_new};
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (job_push) begin
      if (in_last_in_row) begin
        pos_nxt = '0;
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_new;
        cnt_nxt = cnt_new;
        if (pos_r < CNT_W'(MAX_ROW)) pos_nxt = pos_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

/* rtl/grs_back.sv */
// back part: tap window, serial kernel multiply-accumulate, mean divider
// depends on grs_pkg
module grs_back import grs_pkg::*; #(
  parameter int HALF_WIDTH = DEF_HALF_WIDTH,
  parameter int MAX_ROW    = DEF_MAX_ROW,
  localparam int CNT_W     = $clog2(MAX_ROW + 1),
  localparam int SUM_W     = SAMPLE_W + CNT_W,
  localparam int JOB_W     = $bits(job_ctl_t) + SAMPLE_W + SUM_W + CNT_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [JOB_W-1:0]  job_data,
  input  logic              job_empty,
  output logic              job_pop,
  input  logic [COEF_W-1:0] coef [NUM_COEF],
  output result_t           res,
  output logic              res_push,
  input  logic              res_full
);
  localparam int WIN   = 2 * HALF_WIDTH + 1;
  localparam int TAP_W = $clog2(HALF_WIDTH + 2);
  localparam int PROD_W = SAMPLE_W + COEF_W + 2;
  localparam int ACC_W = PROD_W + 4;
  localparam int N_W   = SUM_W + 1;
  localparam int D_W   = CNT_W + 1;
  localparam int REM_W = CNT_W + 2;
  localparam int DC_W  = $clog2(N_W);

  back_state_t               state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] win_r [WIN];
  logic signed [SAMPLE_W-1:0] win_nxt [WIN];
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                      last_r, last_nxt, mm_r, mm_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt, left_r, left_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [TAP_W-1:0]          tap_r, tap_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  result_t                   res_r, res_nxt;
  logic [N_W-1:0]            quo_r, quo_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [D_W-1:0]            den_r, den_nxt;
  logic [DC_W-1:0]           dc_r, dc_nxt;
  logic                      neg_r, neg_nxt;

  job_ctl_t                  j_ctl;
  logic signed [SAMPLE_W-1:0] j_x;
  logic signed [SUM_W-1:0]   j_sum;
  logic [CNT_W-1:0]          j_cnt;
  logic signed [SAMPLE_W:0]  pair [HALF_WIDTH + 1];
  logic [COEF_W-1:0]         tcoef [HALF_WIDTH + 1];
  logic signed [SAMPLE_W:0]  sel_pair;
  logic [COEF_W-1:0]         sel_coef;
  logic signed [ACC_W-1:0]   rnd;
  logic [POS_W-1:0]          pos_inc;
  logic [SUM_W-1:0]          mag;
  logic [REM_W-1:0]          rem_sh;
  logic [SAMPLE_W-1:0]       q32;

  assign {j_ctl, j_x, j_sum, j_cnt} = job_data;
  assign res = res_r;

  for (genvar d = 0; d <= HALF_WIDTH; d++) begin : g_tap
    if (d == 0) begin : g_mid
      assign pair[d] = (SAMPLE_W + 1)'(win_r[HALF_WIDTH]);
    end else begin : g_side
      assign pair[d] = (SAMPLE_W + 1)'(win_r[HALF_WIDTH - d])
                     + (SAMPLE_W + 1)'(win_r[HALF_WIDTH + d]);
    end
    if (d < NUM_COEF) begin : g_coef
      assign tcoef[d] = coef[d];
    end else begin : g_zero
      assign tcoef[d] = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    win_nxt  = win_r;
    x_nxt    = x_r;
    last_nxt = last_r;
    mm_nxt   = mm_r;
    pos_nxt  = pos_r;
    left_nxt = left_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    tap_nxt  = tap_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    dc_nxt   = dc_r;
    neg_nxt  = neg_r;
    job_pop  = 1'b0;
    res_push = 1'b0;
    sel_pair = '0;
    sel_coef = '0;
    for (int d = 0; d <= HALF_WIDTH; d++) begin
      if (tap_r == TAP_W'(d)) begin
        sel_pair = pair[d];
        sel_coef = tcoef[d];
      end
    end
    rnd     = (acc_r + ACC_W'(32768)) >>> 16;
    pos_inc = (pos_r == POS_W'(HALF_WIDTH)) ? pos_r : pos_r + POS_W'(1);
    mag     = (sum_r < 0) ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    rem_sh  = {rem_r[REM_W-2:0], quo_r[N_W-1]};
    q32     = quo_r[SAMPLE_W-1:0];
    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop  = 1'b1;
          x_nxt    = j_x;
          last_nxt = j_ctl.last;
          mm_nxt   = j_ctl.mean_mode;
          pos_nxt  = j_ctl.pos;
          sum_nxt  = j_sum;
          cnt_nxt  = j_cnt;
          left_nxt = j_ctl.last ? POS_W'(HALF_WIDTH) : '0;
          for (int i = 0; i < WIN; i++) begin
            if (j_ctl.first || i == WIN - 1) win_nxt[i] = j_x;
            else win_nxt[i] = win_r[i + 1];
          end
          tap_nxt = '0;
          acc_nxt = '0;
          if (!j_ctl.mean_mode && j_ctl.pos == POS_W'(HALF_WIDTH)) state_nxt = BK_MAC;
          else state_nxt = BK_NEXT;
        end
      end
      BK_MAC: begin
        prod_nxt = PROD_W'(sel_pair) * PROD_W'($signed({1'b0, sel_coef}));
        if (tap_r != '0) acc_nxt = acc_r + ACC_W'(prod_r);
        tap_nxt = tap_r + TAP_W'(1);
        if (tap_r == TAP_W'(HALF_WIDTH + 1)) state_nxt = BK_ROUND;
      end
      BK_ROUND: begin
        if (rnd > ACC_W'(2147483647)) res_nxt.smoothed = 32'h7fffffff;
        else if (rnd < ACC_W'(-64'sd2147483648)) res_nxt.smoothed = 32'h80000000;
        else res_nxt.smoothed = rnd[SAMPLE_W-1:0];
        res_nxt.last_of_row = last_r && (left_r == '0);
        res_nxt.no_kept     = 1'b0;
        state_nxt = BK_WRITE;
      end
      BK_WRITE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = BK_NEXT;
        end
      end
      BK_NEXT: begin
        if (left_r != '0) begin
          for (int i = 0; i < WIN - 1; i++) win_nxt[i] = win_r[i + 1];
          win_nxt[WIN-1] = x_r;
          left_nxt = left_r - POS_W'(1);
          pos_nxt  = pos_inc;
          tap_nxt  = '0;
          acc_nxt  = '0;
          if (!mm_r && pos_inc == POS_W'(HALF_WIDTH)) state_nxt = BK_MAC;
        end else if (last_r && mm_r) begin
          state_nxt = BK_DSET;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DSET: begin
        neg_nxt = sum_r < 0;
        quo_nxt = {mag, 1'b0} + N_W'(cnt_r);
        den_nxt = {cnt_r, 1'b0};
        rem_nxt = '0;
        dc_nxt  = '0;
        res_nxt.last_of_row = 1'b1;
        if (cnt_r == '0) begin
          res_nxt.smoothed = '0;
          res_nxt.no_kept  = 1'b1;
          state_nxt = BK_MWRITE;
        end else begin
          res_nxt.no_kept = 1'b0;
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (dc_r == DC_W'(N_W)) begin
          res_nxt.smoothed = neg_r ? -q32 : q32;
          state_nxt = BK_MWRITE;
        end else begin
          if (rem_sh >= REM_W'(den_r)) begin
            rem_nxt = rem_sh - REM_W'(den_r);
            quo_nxt = {quo_r[N_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            quo_nxt = {quo_r[N_W-2:0], 1'b0};
          end
          dc_nxt = dc_r + DC_W'(1);
        end
      end
      BK_MWRITE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      for (int i = 0; i < WIN; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    last_r <= last_nxt;
    mm_r   <= mm_nxt;
    pos_r  <= pos_nxt;
    left_r <= left_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    tap_r  <= tap_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    dc_r   <= dc_nxt;
    neg_r  <= neg_nxt;
  end
endmodule

/* rtl/gaussian_row_smoother_core.sv */
// channel   | handshake         | payload
// in_       | in_push / in_full | in_sample, in_last_in_row
// out_      | out_pop/out_empty | out_smoothed, out_last_of_row, out_no_kept_samples
// cfg_      | cfg_we            | cfg_index, cfg_data
// a sample with one filtered result is worked out by the single shared
// multiply-accumulate unit walking the symmetric tap pairs
// a row end adds HALF_WIDTH more such passes in filter mode, or a one-bit-a-cycle
// mean division in mean mode
// synchronous active-low reset; two-entry queues on both sides decouple stalls
// top level of the gaussian row smoother; depends on grs_pkg, grs_fifo,
// grs_front, grs_back and gaussian_row_smoother_core_assert.svh
`include "gaussian_row_smoother_core_assert.svh"
module gaussian_row_smoother_core import grs_pkg::*; #(
  parameter int HALF_WIDTH = DEF_HALF_WIDTH,
  parameter int MAX_ROW    = DEF_MAX_ROW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_in_row,
  input  logic                       in_push,
  output logic                       in_full,
  output logic signed [SAMPLE_W-1:0] out_smoothed,
  output logic                       out_last_of_row,
  output logic                       out_no_kept_samples,
  output logic                       out_empty,
  input  logic                       out_pop,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_data
);
  localparam int CNT_W = $clog2(MAX_ROW + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int JOB_W = $bits(job_ctl_t) + SAMPLE_W + SUM_W + CNT_W;

  logic                       mean_mode_r;
  logic signed [SAMPLE_W-1:0] thr_r;
  logic [COEF_W-1:0]          coef_r [NUM_COEF];
  logic                       job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0]           job_wdata, job_rdata;
  result_t                    res_w, res_r;
  logic                       res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_mode_r <= 1'b0;
      thr_r       <= 32'sh7fffffff;
      coef_r[0]   <= COEF_W'(65536);
      for (int i = 1; i < NUM_COEF; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEAN_MODE: mean_mode_r <= cfg_data[0];
        CFG_THRESHOLD: thr_r <= cfg_data;
        CFG_COEF_0:    coef_r[0] <= cfg_data[COEF_W-1:0];
        CFG_COEF_1:    coef_r[1] <= cfg_data[COEF_W-1:0];
        CFG_COEF_2:    coef_r[2] <= cfg_data[COEF_W-1:0];
        CFG_COEF_3:    coef_r[3] <= cfg_data[COEF_W-1:0];
        CFG_COEF_4:    coef_r[4] <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full = job_full;

  grs_front #(.HALF_WIDTH(HALF_WIDTH), .MAX_ROW(MAX_ROW)) u_front (
    .clk, .rst_n, .in_sample, .in_last_in_row, .in_push,
    .job_full, .mean_mode(mean_mode_r), .keep_threshold(thr_r),
    .job_push, .job_data(job_wdata)
  );

  grs_fifo #(.WIDTH(JOB_W)) u_job_q (
    .clk, .rst_n, .push(job_push), .wdata(job_wdata), .full(job_full),
    .pop(job_pop), .empty(job_empty), .rdata(job_rdata)
  );

  grs_back #(.HALF_WIDTH(HALF_WIDTH), .MAX_ROW(MAX_ROW)) u_back (
    .clk, .rst_n, .job_data(job_rdata), .job_empty, .job_pop,
    .coef(coef_r), .res(res_w), .res_push, .res_full
  );

  grs_fifo #(.WIDTH($bits(result_t))) u_res_q (
    .clk, .rst_n, .push(res_push), .wdata(res_w), .full(res_full),
    .pop(out_pop), .empty(out_empty), .rdata(res_r)
  );

  assign out_smoothed        = res_r.smoothed;
  assign out_last_of_row     = res_r.last_of_row;
  assign out_no_kept_samples = res_r.no_kept;

  `GRS_ASSERT_RST(a_empty_after_rst, $past(!rst_n) |-> out_empty, "result queue not empty after reset")
  `GRS_ASSERT(a_job_queued, (in_push && !in_full) |=> !job_empty, "accepted transaction not queued")
  `GRS_ASSERT(a_empty_mean_last, (!out_empty && out_no_kept_samples) |-> out_last_of_row, "empty mean not at row end")
endmodule

/* tb/sv/gaussian_row_smoother_checker.sv */
// checker for the gaussian row smoother: watches the sample, result and register
// ports, predicts every result and compares it field by field; depends on grs_pkg
`timescale 1ns / 100ps
module gaussian_row_smoother_checker import grs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_last_in_row,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] out_smoothed,
  input  logic                       out_last_of_row,
  input  logic                       out_no_kept_samples,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [SAMPLE_W-1:0]        cfg_data,
  output int                         fail_count,
  output int                         pending
);
  localparam int WIN_LEN = 2 * DEF_HALF_WIDTH + 1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
    logic                       no_kept;
  } smooth_result_t;

  smooth_result_t expected_results[$];

  logic                       mean_on;
  logic signed [SAMPLE_W-1:0] threshold;
  logic [COEF_W-1:0]          taps [NUM_COEF];
  logic signed [SAMPLE_W-1:0] window [WIN_LEN];
  int                         row_pos;
  longint                     sum_kept;
  int                         num_kept;

  task automatic report(string what, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d", what, want, got);
    fail_count++;
  endtask

  function automatic void shift_in(logic signed [SAMPLE_W-1:0] x);
    for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i + 1];
    window[WIN_LEN - 1] = x;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] kernel_sum();
    longint acc;
    int d;
    acc = 0;
    for (int t = 0; t < WIN_LEN; t++) begin
      d = t - DEF_HALF_WIDTH;
      if (d < 0) d = -d;
      if (d < NUM_COEF) acc += longint'(taps[d]) * longint'(window[t]);
    end
    acc = (acc + 32768) >>> 16;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[SAMPLE_W-1:0];
  endfunction

  function automatic void add_result(logic signed [SAMPLE_W-1:0] v, logic l, logic nk);
    smooth_result_t r;
    r.value = v;
    r.last = l;
    r.no_kept = nk;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void predict_sample(logic signed [SAMPLE_W-1:0] x, logic last);
    int filled;
    int produced;
    longint mag;
    longint q;
    produced = 0;
    if (row_pos < DEF_MAX_ROW && x <= threshold) begin
      sum_kept += x;
      num_kept++;
    end
    if (row_pos == 0) begin
      for (int i = 0; i <= DEF_HALF_WIDTH; i++) shift_in(x);
    end else begin
      shift_in(x);
    end
    filled = DEF_HALF_WIDTH + row_pos + 1;
    if (!mean_on && filled >= WIN_LEN) begin
      add_result(kernel_sum(), 1'b0, 1'b0);
      produced++;
    end
    if (last) begin
      for (int i = 0; i < DEF_HALF_WIDTH; i++) begin
        shift_in(x);
        filled++;
        if (!mean_on && filled >= WIN_LEN) begin
          add_result(kernel_sum(), 1'b0, 1'b0);
          produced++;
        end
      end
      if (!mean_on) begin
        if (produced > 0) expected_results[$].last = 1'b1;
      end else if (num_kept == 0) begin
        add_result('0, 1'b1, 1'b1);
      end else begin
        mag = sum_kept < 0 ? -sum_kept : sum_kept;
        q = (2 * mag + num_kept) / (2 * longint'(num_kept));
        if (sum_kept < 0) q = -q;
        add_result(q[SAMPLE_W-1:0], 1'b1, 1'b0);
      end
      row_pos = 0;
      sum_kept = 0;
      num_kept = 0;
    end else if (row_pos < DEF_MAX_ROW) begin
      row_pos++;
    end
  endfunction

  always @(posedge clk) begin
    smooth_result_t e;
    if (!rst_n) begin
      mean_on = 1'b0;
      threshold = 32'sh7fffffff;
      taps[0] = 17'd65536;
      for (int i = 1; i < NUM_COEF; i++) taps[i] = '0;
      for (int i = 0; i < WIN_LEN; i++) window[i] = '0;
      row_pos = 0;
      sum_kept = 0;
      num_kept = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index) inside
          CFG_MEAN_MODE: mean_on = cfg_data[0];
          CFG_THRESHOLD: threshold = cfg_data;
          CFG_COEF_0, CFG_COEF_1, CFG_COEF_2, CFG_COEF_3, CFG_COEF_4:
            taps[cfg_index - CFG_COEF_0] = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_sample(in_sample, in_last_in_row);
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report("unexpected transaction, smoothed", 0, out_smoothed);
        end else begin
          e = expected_results.pop_front();
          if (out_smoothed !== e.value) report("smoothed", e.value, out_smoothed);
          if (out_last_of_row !== e.last) report("last_of_row", e.last, out_last_of_row);
          if (out_no_kept_samples !== e.no_kept)
            report("no_kept_samples", e.no_kept, out_no_kept_samples);
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

/* tb/sv/tb_gaussian_row_smoother_core.sv */
// top of the gaussian row smoother testbench: clock, reset, sample and register
// stimulus, result consumer and verdict; depends on grs_pkg and the checker
`timescale 1ns / 100ps
module tb_gaussian_row_smoother_core;
  import grs_pkg::*;

  localparam logic [2:0] CFG_UNMAPPED = 3'd7;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic                       clk;
  logic                       rst_n;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_last_in_row;
  logic                       in_push;
  logic                       in_full;
  logic signed [SAMPLE_W-1:0] out_smoothed;
  logic                       out_last_of_row;
  logic                       out_no_kept_samples;
  logic                       out_empty;
  logic                       out_pop;
  logic                       cfg_we;
  logic [2:0]                 cfg_index;
  logic [SAMPLE_W-1:0]        cfg_data;
  int                         fail_count;
  int                         pending;
  int                         cycles;
  bit                         no_idle;
  bit                         hold_req;

  gaussian_row_smoother_core dut (.*);

  gaussian_row_smoother_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result consumer with random stalls and one long hold-off
  initial begin
    int gap;
    out_pop = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  task automatic push_sample(logic signed [SAMPLE_W-1:0] x, logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_sample <= x;
    in_last_in_row <= last;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [SAMPLE_W-1:0] data);
    in_push <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'h1ffff;
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic send_row(int len);
    for (int i = 0; i < len; i++) push_sample(rand_sample(), i == len - 1);
  endtask

  initial begin
    int budget;
    int len;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_sample = '0;
    in_last_in_row = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MEAN_MODE;
    cfg_data = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // identity kernel from reset, single-sample rows at the extremes
    push_sample(32'sh7fffffff, 1'b1);
    push_sample(32'sh80000000, 1'b1);
    push_sample(32'sh00010000, 1'b0);
    push_sample(-32'sh00018000, 1'b1);
    wait_drained();
    // every tap but the outermost at or above one saturates
    write_reg(CFG_COEF_0, 32'h1ffff);
    write_reg(CFG_COEF_1, 32'd65536);
    write_reg(CFG_COEF_2, 32'd65536);
    write_reg(CFG_COEF_3, 32'h1ffff);
    write_reg(CFG_COEF_4, 32'd1);
    write_reg(CFG_UNMAPPED, 32'hffffffff);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sh00000001, 1'b1);
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sh80000000, 1'b1);
    wait_drained();
    // mean mode, then an empty kept set, then a mode switch mid row
    write_reg(CFG_MEAN_MODE, 32'd1);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh80000000, 1'b1);
    push_sample(-32'sh3, 1'b0);
    push_sample(32'sh0, 1'b1);
    wait_drained();
    write_reg(CFG_THRESHOLD, 32'h80000000);
    push_sample(32'sh00000005, 1'b0);
    push_sample(32'sh7fffffff, 1'b1);
    push_sample(32'sh80000000, 1'b1);
    push_sample(32'sh00000007, 1'b0);
    push_sample(32'sh00000008, 1'b0);
    wait_drained();
    write_reg(CFG_MEAN_MODE, 32'd0);
    push_sample(32'sh00000009, 1'b0);
    push_sample(32'sh0000000a, 1'b1);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_reg(CFG_MEAN_MODE, 32'($urandom_range(0, 2) == 0));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_THRESHOLD, 32'h7fffffff);
        1: write_reg(CFG_THRESHOLD, 32'h80000000);
        default: write_reg(CFG_THRESHOLD, $urandom());
      endcase
      for (int c = 0; c < NUM_COEF; c++)
        if ($urandom_range(0, 1)) write_reg(3'(CFG_COEF_0 + c), rand_coef());
      if (ph == 3) begin
        write_reg(CFG_MEAN_MODE, 32'd0);
        no_idle = 1'b1;
        hold_req = 1'b1;
      end
      budget = 8;
      while (budget > 0) begin
        len = $urandom_range(1, 12);
        send_row(len);
        budget -= len;
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
